// ===== rtl/tte_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tte_pkg
// Shared constants and types for the tap tempo estimator: history sizing,
// tempo limits and the command and status groups between controller and
// datapath.
// ============================================================================
package tte_pkg;

    // Number of intervals averaged (legal range 4..16).
    localparam int HISTORY_DEPTH = 5;

    // Field widths.
    localparam int STAMP_W    = 32;
    localparam int GAP_W      = 16;
    localparam int BPM_W      = 8;

    // Derived widths for the interval history.
    localparam int SLOT_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W      = GAP_W + $clog2(HISTORY_DEPTH);
    localparam int DIV_W      = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    // Tempo arithmetic constants.
    localparam int BPM_NUMERATOR = 60000;
    localparam int BPM_MAX       = 255;
    localparam int BPM_MIN       = 30;
    localparam int MIN_INTERVALS = 3;
    localparam int GAP_RESET     = 2000;

    // Kind of result captured for the current tap.
    typedef enum logic [1:0] {
        RES_NONE    = 2'd0,
        RES_RESTART = 2'd1,
        RES_TEMPO   = 2'd2
    } tte_res_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          tap;
        logic          sum_step;
        logic          div_start;
        logic          div_bpm;
        logic          mean_load;
        logic          res_write;
        tte_res_kind_t res_kind;
        logic          out_load;
    } tte_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gap_over;
        logic enough;
        logic sum_last;
        logic div_done;
        logic mean_zero;
    } tte_stat_t;

endpackage

// ===== rtl/tte_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tte_div
// Restoring unsigned divider that resolves one quotient bit per cycle.
// The quotient stays valid from the done pulse until the next start.
// ============================================================================
module tte_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tte_pkg::DIV_W-1:0]   dividend,
    input  logic [tte_pkg::GAP_W-1:0]   divisor,
    output logic                        done,
    output logic [tte_pkg::DIV_W-1:0]   quotient
);

    logic                            busy_reg;
    logic                            busy_next;
    logic                            done_reg;
    logic                            done_next;
    logic [tte_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [tte_pkg::DIV_CNT_W-1:0]   cnt_next;
    logic [tte_pkg::DIV_W-1:0]       quo_reg;
    logic [tte_pkg::DIV_W-1:0]       quo_next;
    logic [tte_pkg::GAP_W-1:0]       rem_reg;
    logic [tte_pkg::GAP_W-1:0]       rem_next;
    logic [tte_pkg::GAP_W-1:0]       dvs_reg;
    logic [tte_pkg::GAP_W-1:0]       dvs_next;
    logic [tte_pkg::GAP_W:0]         rem_shift;
    logic [tte_pkg::GAP_W:0]         rem_diff;
    logic                            fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign rem_shift = {rem_reg, quo_reg[tte_pkg::DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});

    // Sequencing of the iterations.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = tte_pkg::DIV_CNT_W'(tte_pkg::DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[tte_pkg::DIV_W-2:0], fits};
            rem_next = fits ? rem_diff[tte_pkg::GAP_W-1:0] : rem_shift[tte_pkg::GAP_W-1:0];
            cnt_next = cnt_reg - tte_pkg::DIV_CNT_W'(1);
            if (cnt_reg == tte_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/tte_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tte_dp
// Datapath of the tap tempo estimator: gap measurement, interval history,
// accumulator, shared divider, result and output registers.
// ============================================================================
module tte_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tte_pkg::tte_cmd_t              cmd,
    output tte_pkg::tte_stat_t             stat,
    input  logic                           cfg_we,
    input  logic [tte_pkg::GAP_W-1:0]      cfg_wdata,
    input  logic [tte_pkg::STAMP_W-1:0]    tap_time_ms,
    output logic [tte_pkg::BPM_W-1:0]      tempo_bpm,
    output logic                           tempo_valid,
    output logic                           restarted
);

    logic [tte_pkg::GAP_W-1:0]    gap_limit_reg;
    logic [tte_pkg::STAMP_W-1:0]  last_reg;
    logic [tte_pkg::GAP_W-1:0]    ring_reg [tte_pkg::HISTORY_DEPTH];
    logic [tte_pkg::CNT_W-1:0]    count_reg;
    logic [tte_pkg::CNT_W-1:0]    count_next;
    logic [tte_pkg::SLOT_W-1:0]   slot_reg;
    logic [tte_pkg::SLOT_W-1:0]   slot_next;
    logic [tte_pkg::SLOT_W-1:0]   idx_reg;
    logic [tte_pkg::SUM_W-1:0]    acc_reg;
    logic [tte_pkg::GAP_W-1:0]    mean_reg;
    logic [tte_pkg::BPM_W-1:0]    res_bpm_reg;
    logic                         res_valid_reg;
    logic                         res_restart_reg;
    logic [tte_pkg::BPM_W-1:0]    out_bpm_reg;
    logic                         out_valid_fld_reg;
    logic                         out_restart_reg;

    logic [tte_pkg::STAMP_W-1:0]  gap;
    logic                         gap_over;
    logic [tte_pkg::CNT_W-1:0]    count_inc;
    logic [tte_pkg::DIV_W-1:0]    div_dividend;
    logic [tte_pkg::GAP_W-1:0]    div_divisor;
    logic                         div_done;
    logic [tte_pkg::DIV_W-1:0]    div_quotient;
    logic [tte_pkg::BPM_W-1:0]    bpm_clamped;

    // Gap since the previous tap, modulo 2^32, against the restart limit.
    assign gap      = tap_time_ms - last_reg;
    assign gap_over = (gap > {{(tte_pkg::STAMP_W-tte_pkg::GAP_W){1'b0}}, gap_limit_reg});

    // History bookkeeping: count saturates, write slot wraps.
    assign count_inc  = (count_reg == tte_pkg::CNT_W'(tte_pkg::HISTORY_DEPTH)) ?
                        count_reg : count_reg + tte_pkg::CNT_W'(1);
    assign count_next = gap_over ? '0 : count_inc;
    assign slot_next  = gap_over ? '0 :
                        ((slot_reg == tte_pkg::SLOT_W'(tte_pkg::HISTORY_DEPTH - 1)) ?
                         '0 : slot_reg + tte_pkg::SLOT_W'(1));

    // Status toward the controller.
    assign stat.gap_over  = gap_over;
    assign stat.enough    = (count_inc > tte_pkg::CNT_W'(tte_pkg::MIN_INTERVALS));
    assign stat.sum_last  = ((tte_pkg::CNT_W'(idx_reg) + tte_pkg::CNT_W'(1)) == count_reg);
    assign stat.div_done  = div_done;
    assign stat.mean_zero = (div_quotient == '0);

    // The shared divider first forms the mean, then the tempo.
    assign div_dividend = cmd.div_bpm ? tte_pkg::DIV_W'(tte_pkg::BPM_NUMERATOR) : acc_reg;
    assign div_divisor  = cmd.div_bpm ? mean_reg : tte_pkg::GAP_W'(count_reg);

    tte_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Tempo clamped to the supported range.
    always_comb
    begin
        if (div_quotient > tte_pkg::DIV_W'(tte_pkg::BPM_MAX))
        begin
            bpm_clamped = tte_pkg::BPM_W'(tte_pkg::BPM_MAX);
        end
        else if (div_quotient < tte_pkg::DIV_W'(tte_pkg::BPM_MIN))
        begin
            bpm_clamped = tte_pkg::BPM_W'(tte_pkg::BPM_MIN);
        end
        else
        begin
            bpm_clamped = div_quotient[tte_pkg::BPM_W-1:0];
        end
    end

    // Configuration and history control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg <= tte_pkg::GAP_W'(tte_pkg::GAP_RESET);
            last_reg      <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                gap_limit_reg <= cfg_wdata;
            end
            if (cmd.tap)
            begin
                last_reg  <= tap_time_ms;
                count_reg <= count_next;
                slot_reg  <= slot_next;
            end
        end
    end

    // Interval ring write on a counted tap.
    always_ff @(posedge clk)
    begin
        if (cmd.tap && !gap_over)
        begin
            ring_reg[slot_reg] <= gap[tte_pkg::GAP_W-1:0];
        end
    end

    // Accumulation of the held intervals, one entry per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.tap)
        begin
            acc_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd.sum_step)
        begin
            acc_reg <= acc_reg + tte_pkg::SUM_W'(ring_reg[idx_reg]);
            idx_reg <= idx_reg + tte_pkg::SLOT_W'(1);
        end
        if (cmd.mean_load)
        begin
            mean_reg <= div_quotient[tte_pkg::GAP_W-1:0];
        end
    end

    // Result of the current tap.
    always_ff @(posedge clk)
    begin
        if (cmd.res_write)
        begin
            unique case (cmd.res_kind)
                tte_pkg::RES_RESTART:
                begin
                    res_bpm_reg     <= '0;
                    res_valid_reg   <= 1'b0;
                    res_restart_reg <= 1'b1;
                end
                tte_pkg::RES_TEMPO:
                begin
                    res_bpm_reg     <= bpm_clamped;
                    res_valid_reg   <= 1'b1;
                    res_restart_reg <= 1'b0;
                end
                default:
                begin
                    res_bpm_reg     <= '0;
                    res_valid_reg   <= 1'b0;
                    res_restart_reg <= 1'b0;
                end
            endcase
        end
    end

    // Output register, loaded when the output slot is free.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_bpm_reg       <= res_bpm_reg;
            out_valid_fld_reg <= res_valid_reg;
            out_restart_reg   <= res_restart_reg;
        end
    end

    assign tempo_bpm   = out_bpm_reg;
    assign tempo_valid = out_valid_fld_reg;
    assign restarted   = out_restart_reg;

endmodule

// ===== rtl/tte_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tte_ctrl
// Controller of the tap tempo estimator: sequences gap check, summing,
// the two divisions and the hand-off to the output register.
// ============================================================================
module tte_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tte_pkg::tte_stat_t   stat,
    output tte_pkg::tte_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SUM     = 7'b0000010,
        ST_MEAN_GO = 7'b0000100,
        ST_MEAN    = 7'b0001000,
        ST_BPM_GO  = 7'b0010000,
        ST_BPM     = 7'b0100000,
        ST_DONE    = 7'b1000000
    } tte_state_t;

    tte_state_t state_reg;
    tte_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output slot is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_kind   = tte_pkg::RES_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.tap = 1'b1;
                    if (stat.gap_over)
                    begin
                        cmd.res_write = 1'b1;
                        cmd.res_kind  = tte_pkg::RES_RESTART;
                        state_next    = ST_DONE;
                    end
                    else if (!stat.enough)
                    begin
                        cmd.res_write = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.sum_last)
                begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN;
            end
            ST_MEAN:
            begin
                if (stat.div_done)
                begin
                    if (stat.mean_zero)
                    begin
                        cmd.res_write = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        cmd.mean_load = 1'b1;
                        state_next    = ST_BPM_GO;
                    end
                end
            end
            ST_BPM_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_bpm   = 1'b1;
                state_next    = ST_BPM;
            end
            ST_BPM:
            begin
                if (stat.div_done)
                begin
                    cmd.res_write = 1'b1;
                    cmd.res_kind  = tte_pkg::RES_TEMPO;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output handshake registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/tap_tempo_bpm_estimator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tap_tempo_bpm_estimator
// Tap tempo estimator: averages the recent tap intervals and converts the
// mean interval into beats per minute.
// ============================================================================
//
//  Channel  | Signals                                   | Handshake
//  ---------+-------------------------------------------+-------------------
//  input    | tap_time_ms                               | in_valid/in_ready
//  output   | tempo_bpm, tempo_valid, restarted         | out_valid/out_ready
//  config   | cfg_wdata (restart gap in ms)             | cfg_we, no wait
//
//  A tap is processed one at a time. A restart or a short history passes
//  the result register and the done state to the output register; a tempo
//  first goes through the sum and the mean and tempo divisions, with the
//  sum taking one entry per cycle and the divider one quotient bit per cycle.
//  The next transaction is accepted while a result waits in the output
//  register; a stalled output holds the controller only once the next
//  result is ready. Reset is asynchronous and clears the history.
// ============================================================================
module tap_tempo_bpm_estimator
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tte_pkg::STAMP_W-1:0]    tap_time_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tte_pkg::BPM_W-1:0]      tempo_bpm,
    output logic                           tempo_valid,
    output logic                           restarted,
    input  logic                           cfg_we,
    input  logic [tte_pkg::GAP_W-1:0]      cfg_wdata
);

    tte_pkg::tte_cmd_t  cmd;
    tte_pkg::tte_stat_t stat;

    // Sequencer.
    tte_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and storage.
    tte_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .tap_time_ms (tap_time_ms),
        .tempo_bpm   (tempo_bpm),
        .tempo_valid (tempo_valid),
        .restarted   (restarted)
    );

endmodule

// ===== rtl/tte_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tte_checker
// Port-level checks of the tap tempo estimator, bound to the top level.
// ============================================================================
module tte_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [tte_pkg::BPM_W-1:0]      tempo_bpm,
    input  logic                           tempo_valid,
    input  logic                           restarted
);

    // A tempo and a restart never come with the same result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tempo_valid) |-> !restarted)
    else $error("tempo reported together with restart");

    // A reported tempo lies in the clamped range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tempo_valid) |-> (tempo_bpm >= tte_pkg::BPM_W'(tte_pkg::BPM_MIN)))
    else $error("tempo below the minimum");

    // Without a tempo the bpm field reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tempo_valid) |-> (tempo_bpm == '0))
    else $error("bpm nonzero without a tempo");

    // One tap at a time: no acceptance in the cycle after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("second tap accepted back to back");

    // A stalled result holds its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(tempo_bpm) && $stable(tempo_valid) && $stable(restarted)))
    else $error("stalled result changed");

endmodule

bind tap_tempo_bpm_estimator tte_checker u_tte_checker (.*);

// ===== tb/sv/tb_tap_tempo_bpm_estimator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_tap_tempo_bpm_estimator
// Self-checking testbench for the tap tempo estimator. A queue-fed driver
// offers tap timestamps and a monitor predicts each result from its own
// model of the interval history, then compares every tempo result field by
// field. Runs cover several restart-gap settings, random idling on both
// channels and one long output stall that backs the block up.
// ============================================================================
module tb_tap_tempo_bpm_estimator;

    // One tempo result as seen on the output channel.
    typedef struct packed {
        logic [tte_pkg::BPM_W-1:0] bpm;
        logic                      valid;
        logic                      restarted;
    } tempo_result_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    logic [tte_pkg::STAMP_W-1:0]    tap_time_ms = '0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    logic [tte_pkg::BPM_W-1:0]      tempo_bpm;
    logic                           tempo_valid;
    logic                           restarted;
    logic                           cfg_we      = 1'b0;
    logic [tte_pkg::GAP_W-1:0]      cfg_wdata   = '0;

    // Taps waiting to be offered, and tempo results owed by the block.
    logic [tte_pkg::STAMP_W-1:0]    tap_queue[$];
    tempo_result_t                  tempo_expected[$];

    // Estimator state as the testbench tracks it.
    logic [tte_pkg::STAMP_W-1:0]    est_last_stamp = '0;
    logic [tte_pkg::GAP_W-1:0]      est_ring[tte_pkg::HISTORY_DEPTH];
    int                             est_count      = 0;
    int                             est_slot       = 0;
    logic [tte_pkg::GAP_W-1:0]      est_gap_limit  = tte_pkg::GAP_W'(tte_pkg::GAP_RESET);

    // Traffic shaping shared between the stimulus and the two channel drivers.
    int                   send_idle_pct  = 0;
    int                   recv_idle_pct  = 0;
    logic                 calm           = 1'b0;
    int                   hold_requested = 0;
    int                   holds_served   = 0;
    int                   hold_left      = 0;
    int                   send_gap       = 0;
    int                   stall_left     = 0;
    logic                 tap_taken      = 1'b0;
    logic [tte_pkg::STAMP_W-1:0] stamp_cursor = '0;

    // Run bookkeeping.
    int                   taps_accepted  = 0;
    int                   results_checked = 0;
    int                   tempos_seen    = 0;
    int                   restarts_seen  = 0;
    int                   mismatch_count = 0;
    int                   settings_used  = 1;

    tap_tempo_bpm_estimator dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tap_time_ms (tap_time_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tempo_bpm   (tempo_bpm),
        .tempo_valid (tempo_valid),
        .restarted   (restarted),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Advance the tracked history by one tap and return the tempo it yields.
    function automatic tempo_result_t predict_tempo(input logic [tte_pkg::STAMP_W-1:0] stamp);
        logic [tte_pkg::STAMP_W-1:0] gap;
        int unsigned        sum;
        int unsigned        mean;
        int unsigned        bpm;
        int                 i;
        tempo_result_t      res;
        res = '0;
        gap = stamp - est_last_stamp;
        est_last_stamp = stamp;
        if (gap > est_gap_limit)
        begin
            est_count = 0;
            est_slot  = 0;
            res.restarted = 1'b1;
        end
        else
        begin
            est_ring[est_slot] = gap[tte_pkg::GAP_W-1:0];
            est_slot = (est_slot == tte_pkg::HISTORY_DEPTH - 1) ? 0 : est_slot + 1;
            if (est_count < tte_pkg::HISTORY_DEPTH)
                est_count++;
            if (est_count > tte_pkg::MIN_INTERVALS)
            begin
                sum = 0;
                for (i = 0; i < est_count; i++)
                    sum += est_ring[i];
                mean = sum / est_count;
                if (mean != 0)
                begin
                    bpm = tte_pkg::BPM_NUMERATOR / mean;
                    if (bpm > tte_pkg::BPM_MAX)
                        bpm = tte_pkg::BPM_MAX;
                    if (bpm < tte_pkg::BPM_MIN)
                        bpm = tte_pkg::BPM_MIN;
                    res.bpm   = bpm[tte_pkg::BPM_W-1:0];
                    res.valid = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Monitor: predict on each accepted tap, check each accepted result.
    always @(posedge clk)
    begin : monitor
        tempo_result_t want;
        tempo_result_t owed;
        tap_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            owed = predict_tempo(tap_time_ms);
            tempo_expected = {tempo_expected, owed};
            taps_accepted <= taps_accepted + 1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_checked <= results_checked + 1;
            if (tempo_valid)
                tempos_seen <= tempos_seen + 1;
            if (restarted)
                restarts_seen <= restarts_seen + 1;
            if (tempo_expected.size() == 0)
            begin
                $error("unexpected result: tempo_bpm %0d tempo_valid %0b restarted %0b",
                       tempo_bpm, tempo_valid, restarted);
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                want = tempo_expected[0];
                tempo_expected.delete(0);
                if (tempo_bpm !== want.bpm || tempo_valid !== want.valid ||
                    restarted !== want.restarted)
                    mismatch_count <= mismatch_count + 1;
                if (tempo_bpm !== want.bpm)
                    $error("tempo_bpm: expected %0d, actual %0d", want.bpm, tempo_bpm);
                if (tempo_valid !== want.valid)
                    $error("tempo_valid: expected %0b, actual %0b", want.valid, tempo_valid);
                if (restarted !== want.restarted)
                    $error("restarted: expected %0b, actual %0b", want.restarted, restarted);
            end
        end
    end

    // Tap driver: holds each transaction until accepted, with idle bursts.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !tap_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (tap_queue.size() > 0)
            begin
                if (!calm && $urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap <= $urandom_range(0, 12);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid    <= 1'b1;
                    tap_time_ms <= tap_queue[0];
                    tap_queue.delete(0);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: random stall bursts plus an occasional long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holds_served != hold_requested)
            begin
                holds_served <= hold_requested;
                hold_left    <= 400;
                out_ready    <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_left <= $urandom_range(0, 12);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Wait until every tap is accepted and every result has come back.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (tap_queue.size() != 0 || in_valid || taps_accepted != results_checked);
    endtask

    // Write the restart gap while the block is idle.
    task automatic write_restart_gap(input logic [tte_pkg::GAP_W-1:0] value);
        @(negedge clk);
        cfg_we        <= 1'b1;
        cfg_wdata     <= value;
        est_gap_limit  = value;
        @(negedge clk);
        cfg_we        <= 1'b0;
    endtask

    // Queue random taps: mostly steady tapping, with restarts, repeated
    // timestamps and jumps toward the timestamp wrap mixed in.
    task automatic queue_taps(input int count, input int unsigned limit);
        int          made;
        int          run_len;
        int          kind;
        int          k;
        int unsigned base;
        int unsigned spread;
        int unsigned step;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 14)
            begin
                run_len = $urandom_range(4, 12);
                if ($urandom_range(0, 1) == 1 && limit >= 200)
                    base = $urandom_range(200, (limit > 2000) ? 2000 : limit);
                else
                    base = $urandom_range(0, limit);
                spread = base / 8;
                for (k = 0; k < run_len; k++)
                begin
                    step = base - spread + $urandom_range(0, 2 * spread);
                    if (step > limit || $urandom_range(0, 15) == 0)
                        step = limit;
                    stamp_cursor += step;
                    tap_queue = {tap_queue, stamp_cursor};
                end
                made += run_len;
            end
            else if (kind < 16)
            begin
                // Gap just past the limit, or a jump anywhere.
                if ($urandom_range(0, 1) == 1)
                    stamp_cursor += limit + 1 + $urandom_range(0, 3);
                else
                    stamp_cursor = $urandom();
                tap_queue = {tap_queue, stamp_cursor};
                made++;
            end
            else if (kind < 18)
            begin
                // Repeated timestamps give zero intervals.
                run_len = $urandom_range(4, 6);
                for (k = 0; k < run_len; k++)
                    tap_queue = {tap_queue, stamp_cursor};
                made += run_len;
            end
            else
            begin
                // Land just below the wrap so the next run crosses it.
                stamp_cursor = 32'hFFFF_FFFF - $urandom_range(0, 4 * limit + 4);
                tap_queue = {tap_queue, stamp_cursor};
                made++;
            end
        end
    endtask

    // Stimulus: reset, directed taps, then random phases per gap setting.
    initial
    begin : stimulus
        logic [tte_pkg::STAMP_W-1:0] opening_taps[15];
        logic [tte_pkg::GAP_W-1:0]   gap_settings[10];
        int                          phase;
        // First tap from zero, short history, a tempo, a gap equal to the
        // limit, a restart, a zero mean, then a run across the wrap.
        opening_taps = '{32'd500, 32'd1000, 32'd1500, 32'd2000, 32'd4000,
                         32'd6001, 32'd6001, 32'd6001, 32'd6001, 32'd6001,
                         32'hFFFF_FF00, 32'hFFFF_FF80, 32'hFFFF_FFFF, 32'h0, 32'h40};
        gap_settings = '{16'd2000, 16'hFFFF, 16'd0, 16'd1, 16'd0,
                         16'd300, 16'd0, 16'd5000, 16'd0, 16'd2000};
        gap_settings[4] = tte_pkg::GAP_W'($urandom());
        gap_settings[6] = tte_pkg::GAP_W'($urandom());
        gap_settings[8] = tte_pkg::GAP_W'($urandom_range(200, 3000));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (opening_taps[i])
            tap_queue = {tap_queue, opening_taps[i]};
        wait_idle();

        // Widest gap: maximum intervals clamp to the slowest tempo.
        write_restart_gap(16'hFFFF);
        settings_used++;
        @(posedge clk);
        stamp_cursor = 32'h40;
        repeat (5)
        begin
            stamp_cursor += 32'd65535;
            tap_queue = {tap_queue, stamp_cursor};
        end
        stamp_cursor += 32'd65536;
        tap_queue = {tap_queue, stamp_cursor};
        wait_idle();

        for (phase = 0; phase < 10; phase++)
        begin
            write_restart_gap(gap_settings[phase]);
            settings_used++;
            @(posedge clk);
            if (phase == 9)
                calm = 1'b1;
            else if (phase == 0)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = 20 * $urandom_range(0, 3);
                recv_idle_pct = 20 * $urandom_range(0, 3);
            end
            if (phase == 5)
                hold_requested++;
            queue_taps(103, gap_settings[phase]);
            wait_idle();
        end

        repeat (60) @(posedge clk);
        $display("Covered %0d taps under %0d restart-gap settings, idling and a long stall.",
                 taps_accepted, settings_used);
        $display("Results: %0d tempos, %0d restarts, %0d with no tempo.",
                 tempos_seen, restarts_seen, results_checked - tempos_seen - restarts_seen);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tte_pkg.sv
rtl/tte_div.sv
rtl/tte_dp.sv
rtl/tte_ctrl.sv
rtl/tap_tempo_bpm_estimator.sv
rtl/tte_checker.sv
tb/sv/tb_tap_tempo_bpm_estimator.sv
